### hw/rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants for the LZSS stream decompressor: controller
// states, result source select, status codes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned DIST_W     = 13;
  localparam int unsigned LEN_W      = 5;

  localparam logic [1:0]  HDR_BYTES_SHORT = 2'd2;
  localparam logic [1:0]  HDR_BYTES_LONG  = 2'd3;
  localparam logic [3:0]  FLAGS_PER_TOKEN = 4'd8;
  localparam logic [DIST_W-1:0] DIST_BIAS = 13'd3;
  localparam logic [LEN_W-1:0]  LEN_BIAS  = 5'd3;

  localparam logic [1:0]  STATUS_RUN     = 2'd0;
  localparam logic [1:0]  STATUS_DONE    = 2'd1;
  localparam logic [1:0]  STATUS_CORRUPT = 2'd2;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_TOKEN,
    ST_LITERAL,
    ST_MATCH_HI,
    ST_MATCH_LO,
    ST_COPY,
    ST_DONE,
    ST_ERROR
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_LIT,
    RES_COPY
  } res_sel_e;

  typedef struct packed {
    logic       header_shift;
    logic       token_load;
    logic       high_load;
    logic       copy_start;
    logic       emit;
    res_sel_e   emit_sel;
    logic       advance;
    logic       res_load;
    res_sel_e   res_sel;
    logic [1:0] res_status;
    logic       res_last;
  } lzss_cmd_t;

  typedef struct packed {
    logic hdr_done;
    logic hdr_zero;
    logic tok_msb;
    logic match_err;
    logic adv_done;
    logic flags_end;
    logic flag_next_msb;
    logic out_free;
    logic copy_ready;
    logic copy_last;
  } lzss_sts_t;

endpackage

### hw/rtl/lzss_dp.sv
// ----------------------------------------------------------------------------
// lzss_dp
// Datapath: size header, flag shifter, history memory with a one-byte read
// pipeline for match copies, produced count and the output register.
// ----------------------------------------------------------------------------
module lzss_dp #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     size_field_mode_we_i,
  input  logic                     size_field_mode_i,
  input  logic [7:0]               in_byte_i,
  input  lzss_pkg::lzss_cmd_t      cmd_i,
  output lzss_pkg::lzss_sts_t      sts_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               out_byte_o,
  output logic                     byte_valid_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W+1)'(HISTORY_DEPTH);

  logic [7:0] mem_q [HISTORY_DEPTH];

  logic                              mode_q;
  logic [1:0]                        hc_q, hc_d;
  logic [lzss_pkg::SIZE_W-1:0]       target_q, target_d;
  logic [lzss_pkg::SIZE_W-1:0]       produced_q, produced_d;
  logic [7:0]                        flag_q, flag_d;
  logic [3:0]                        left_q, left_d;
  logic [7:0]                        high_q, high_d;
  logic [PTR_W-1:0]                  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]                  rd_ptr_q, rd_ptr_d;
  logic [lzss_pkg::LEN_W-1:0]        rd_left_q, rd_left_d;
  logic [lzss_pkg::LEN_W-1:0]        em_left_q, em_left_d;
  logic                              rd_vld_q, rd_vld_d;
  logic [7:0]                        rd_data_q;

  logic                              out_valid_q, out_valid_d;
  logic [7:0]                        out_byte_q, out_byte_d;
  logic                              byte_valid_q, byte_valid_d;
  logic [1:0]                        status_q, status_d;
  logic                              last_q, last_d;

  logic [1:0]                        hc_inc;
  logic [1:0]                        hdr_need;
  logic [lzss_pkg::SIZE_W-1:0]       target_shift;
  logic [15:0]                       word;
  logic [lzss_pkg::DIST_W-1:0]       match_dist;
  logic [lzss_pkg::LEN_W-1:0]        len;
  logic [lzss_pkg::SIZE_W:0]         end_pos;
  logic [PTR_W:0]                    src_diff;
  logic [PTR_W-1:0]                  src_ptr;
  logic                              out_free;
  logic                              rd_issue;
  logic [7:0]                        emit_byte;

  // header and match decode
  assign hc_inc       = hc_q + 2'd1;
  assign hdr_need     = mode_q ? lzss_pkg::HDR_BYTES_LONG : lzss_pkg::HDR_BYTES_SHORT;
  assign target_shift = {target_q[15:0], in_byte_i};
  assign word         = {high_q, in_byte_i};
  assign match_dist   = {1'b0, word[15:4]} + lzss_pkg::DIST_BIAS;
  assign len          = {1'b0, word[3:0]} + lzss_pkg::LEN_BIAS;
  assign end_pos      = {1'b0, produced_q} + (lzss_pkg::SIZE_W+1)'(len);
  assign src_diff     = {1'b0, wr_ptr_q} - (PTR_W+1)'(match_dist);
  assign src_ptr      = src_diff[PTR_W] ? PTR_W'(src_diff + DEPTH_EXT) : src_diff[PTR_W-1:0];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign rd_issue  = (rd_left_q != '0) && (!rd_vld_q || cmd_i.emit);
  assign emit_byte = (cmd_i.emit_sel == lzss_pkg::RES_COPY) ? rd_data_q : in_byte_i;

  always_comb begin
    sts_o.hdr_done      = hc_inc >= hdr_need;
    sts_o.hdr_zero      = target_shift == '0;
    sts_o.tok_msb       = in_byte_i[7];
    sts_o.match_err     = (lzss_pkg::SIZE_W'(match_dist) > produced_q) ||
                          (end_pos > {1'b0, target_q});
    sts_o.adv_done      = (produced_q + 24'd1) >= target_q;
    sts_o.flags_end     = left_q <= 4'd1;
    sts_o.flag_next_msb = flag_q[6];
    sts_o.out_free      = out_free;
    sts_o.copy_ready    = rd_vld_q && out_free;
    sts_o.copy_last     = em_left_q == lzss_pkg::LEN_W'(1);
  end

  always_comb begin
    hc_d       = hc_q;
    target_d   = target_q;
    produced_d = produced_q;
    flag_d     = flag_q;
    left_d     = left_q;
    high_d     = high_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    rd_left_d  = rd_left_q;
    em_left_d  = em_left_q;
    rd_vld_d   = rd_vld_q;

    if (cmd_i.header_shift) begin
      hc_d     = hc_inc;
      target_d = target_shift;
      left_d   = '0;
    end
    if (cmd_i.token_load) begin
      flag_d = in_byte_i;
      left_d = lzss_pkg::FLAGS_PER_TOKEN;
    end
    if (cmd_i.high_load) begin
      high_d = in_byte_i;
    end
    if (cmd_i.copy_start) begin
      rd_ptr_d  = src_ptr;
      rd_left_d = len;
      em_left_d = len;
      rd_vld_d  = 1'b0;
    end
    if (cmd_i.emit) begin
      produced_d = produced_q + 24'd1;
      wr_ptr_d   = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      if (cmd_i.emit_sel == lzss_pkg::RES_COPY) begin
        em_left_d = em_left_q - lzss_pkg::LEN_W'(1);
        rd_vld_d  = 1'b0;
      end
    end
    if (rd_issue) begin
      rd_ptr_d  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      rd_left_d = rd_left_q - lzss_pkg::LEN_W'(1);
      rd_vld_d  = 1'b1;
    end
    if (cmd_i.advance) begin
      flag_d = {flag_q[6:0], 1'b0};
      if (left_q != '0) begin
        left_d = left_q - 4'd1;
      end
    end
  end

  // output register, reloaded in the same cycle the held beat leaves
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    status_d     = status_q;
    last_d       = last_q;
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
      status_d    = cmd_i.res_status;
      last_d      = cmd_i.res_last;
      case (cmd_i.res_sel)
        lzss_pkg::RES_LIT: begin
          out_byte_d   = in_byte_i;
          byte_valid_d = 1'b1;
        end
        lzss_pkg::RES_COPY: begin
          out_byte_d   = rd_data_q;
          byte_valid_d = 1'b1;
        end
        default: begin
          out_byte_d   = '0;
          byte_valid_d = 1'b0;
        end
      endcase
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      hc_q        <= '0;
      target_q    <= '0;
      produced_q  <= '0;
      flag_q      <= '0;
      left_q      <= '0;
      high_q      <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      rd_left_q   <= '0;
      em_left_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (size_field_mode_we_i) begin
        mode_q <= size_field_mode_i;
      end
      hc_q        <= hc_d;
      target_q    <= target_d;
      produced_q  <= produced_d;
      flag_q      <= flag_d;
      left_q      <= left_d;
      high_q      <= high_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_left_q   <= rd_left_d;
      em_left_q   <= em_left_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    status_q     <= status_d;
    last_q       <= last_d;
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      mem_q[wr_ptr_q] <= emit_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

### hw/rtl/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Controller: decode phase state machine. Decides what each input beat does
// and paces the match copy one byte per free output slot.
// ----------------------------------------------------------------------------
module lzss_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 input_over_i,
  output logic                 in_stall_o,
  input  lzss_pkg::lzss_sts_t  sts_i,
  output lzss_pkg::lzss_cmd_t  cmd_o
);

  lzss_pkg::ctrl_state_e state_q, state_d;
  lzss_pkg::ctrl_state_e adv_state;
  logic                  take;
  logic [1:0]            adv_status;

  assign in_stall_o = (state_q == lzss_pkg::ST_COPY) || !sts_i.out_free;
  assign take       = in_valid_i && !in_stall_o;

  // where decoding goes once a literal or a whole match is done
  always_comb begin
    if (sts_i.adv_done) begin
      adv_state = lzss_pkg::ST_DONE;
    end else if (sts_i.flags_end) begin
      adv_state = lzss_pkg::ST_TOKEN;
    end else if (sts_i.flag_next_msb) begin
      adv_state = lzss_pkg::ST_MATCH_HI;
    end else begin
      adv_state = lzss_pkg::ST_LITERAL;
    end
  end
  assign adv_status = sts_i.adv_done ? lzss_pkg::STATUS_DONE : lzss_pkg::STATUS_RUN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzss_pkg::ST_HEADER;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (state_q == lzss_pkg::ST_COPY) begin
      if (sts_i.copy_ready) begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_sel = lzss_pkg::RES_COPY;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = lzss_pkg::RES_COPY;
        cmd_o.res_last = sts_i.copy_last;
        if (sts_i.copy_last) begin
          cmd_o.advance    = 1'b1;
          cmd_o.res_status = adv_status;
          state_d          = adv_state;
        end
      end
    end else if (take) begin
      // every beat but a good match word answers with one result at once
      cmd_o.res_load = 1'b1;
      cmd_o.res_sel  = lzss_pkg::RES_NONE;
      cmd_o.res_last = 1'b1;
      if (state_q == lzss_pkg::ST_DONE) begin
        cmd_o.res_status = lzss_pkg::STATUS_DONE;
      end else if (state_q == lzss_pkg::ST_ERROR) begin
        cmd_o.res_status = lzss_pkg::STATUS_CORRUPT;
      end else if (input_over_i) begin
        cmd_o.res_status = lzss_pkg::STATUS_CORRUPT;
        state_d          = lzss_pkg::ST_ERROR;
      end else begin
        case (state_q)
          lzss_pkg::ST_HEADER: begin
            cmd_o.header_shift = 1'b1;
            if (sts_i.hdr_done) begin
              if (sts_i.hdr_zero) begin
                cmd_o.res_status = lzss_pkg::STATUS_DONE;
                state_d          = lzss_pkg::ST_DONE;
              end else begin
                state_d = lzss_pkg::ST_TOKEN;
              end
            end
          end
          lzss_pkg::ST_TOKEN: begin
            cmd_o.token_load = 1'b1;
            state_d = sts_i.tok_msb ? lzss_pkg::ST_MATCH_HI : lzss_pkg::ST_LITERAL;
          end
          lzss_pkg::ST_LITERAL: begin
            cmd_o.emit       = 1'b1;
            cmd_o.emit_sel   = lzss_pkg::RES_LIT;
            cmd_o.advance    = 1'b1;
            cmd_o.res_sel    = lzss_pkg::RES_LIT;
            cmd_o.res_status = adv_status;
            state_d          = adv_state;
          end
          lzss_pkg::ST_MATCH_HI: begin
            cmd_o.high_load = 1'b1;
            state_d         = lzss_pkg::ST_MATCH_LO;
          end
          lzss_pkg::ST_MATCH_LO: begin
            if (sts_i.match_err) begin
              cmd_o.res_status = lzss_pkg::STATUS_CORRUPT;
              state_d          = lzss_pkg::ST_ERROR;
            end else begin
              cmd_o.res_load   = 1'b0;
              cmd_o.copy_start = 1'b1;
              state_d          = lzss_pkg::ST_COPY;
            end
          end
          default: begin
            cmd_o.res_status = lzss_pkg::STATUS_CORRUPT;
            state_d          = lzss_pkg::ST_ERROR;
          end
        endcase
      end
    end
  end

endmodule

### hw/rtl/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a distance window of 3 to 4098 bytes: reads a size header, then token
// bytes whose flags select literals or history matches, and emits the data.
//
//   channel   dir  handshake                  beat
//   input     in   in_valid_i / in_stall_o    in_byte_i, input_over_i
//   result    out  out_valid_o / out_stall_i  out_byte_o, byte_valid_o,
//                                             status_o, last_o
//   config    in   size_field_mode_we_i       size_field_mode_i
//
// each header, token, literal or match-high byte is decoded as it is taken; a
// match word starts a copy of 3 to 18 bytes, each read out of history through
// the single registered read port of the history memory and then emitted;
// output stalls hold the copy; input is stalled during a copy and while a
// result waits in the output register
// reset clears all control state; the history memory is not cleared
// ----------------------------------------------------------------------------
module lzss_stream_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 8192
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       size_field_mode_we_i,
  input  logic       size_field_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       input_over_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  lzss_pkg::lzss_cmd_t cmd;
  lzss_pkg::lzss_sts_t sts;

  lzss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .input_over_i (input_over_i),
    .in_stall_o   (in_stall_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  lzss_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .size_field_mode_we_i (size_field_mode_we_i),
    .size_field_mode_i    (size_field_mode_i),
    .in_byte_i            (in_byte_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_byte_o           (out_byte_o),
    .byte_valid_o         (byte_valid_o),
    .status_o             (status_o),
    .last_o               (last_o)
  );

endmodule
